@@ src/bms_pkg.sv @@
// Shared types, constants and song tables for the button melody sequencer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

    // Song and register defaults
    localparam int SONG_LENGTH_DEF = 14;
    localparam int CFG_W           = 10;
    localparam int CFG_IDX_W       = 2;
    localparam int NOTE_W          = 10;
    localparam int GAP_W           = 8;
    localparam int POS_W           = 4;
    localparam int TONE_W          = 16;

    localparam logic [NOTE_W-1:0] SHORT_RST = 10'd500;
    localparam logic [NOTE_W-1:0] LONG_RST  = 10'd1000;
    localparam logic [GAP_W-1:0]  GAP_RST   = 8'd10;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP   = 2'd2;

    // Tone compare values: 62500/f - 1, truncated
    localparam logic [TONE_W-1:0] TONE_C4 = 16'd237;
    localparam logic [TONE_W-1:0] TONE_D4 = 16'd211;
    localparam logic [TONE_W-1:0] TONE_E4 = 16'd188;
    localparam logic [TONE_W-1:0] TONE_F4 = 16'd177;
    localparam logic [TONE_W-1:0] TONE_G4 = 16'd158;
    localparam logic [TONE_W-1:0] TONE_A4 = 16'd141;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_OFF      = 3'd1,
        MODE_ARMED    = 3'd2,
        MODE_PLAYING  = 3'd3,
        MODE_FINISHED = 3'd4
    } mode_t;

    typedef struct packed {
        logic [NOTE_W-1:0] short_ticks;
        logic [NOTE_W-1:0] long_ticks;
        logic [GAP_W-1:0]  gap_ticks;
    } bms_cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [POS_W-1:0]  pos;
        logic [NOTE_W-1:0] note_timer;
        logic [GAP_W-1:0]  gap_timer;
    } bms_state_t;

    typedef struct packed {
        mode_t             mode;
        logic              sounding;
        logic [TONE_W-1:0] tone_period;
        logic [POS_W-1:0]  note_index;
    } bms_result_t;

    // Note pitch by song position; positions past the song are silent
    function automatic logic [TONE_W-1:0] note_tone(input logic [POS_W-1:0] idx);
        logic [TONE_W-1:0] t;
        case (idx)
            4'd0, 4'd1, 4'd13:       t = TONE_C4;
            4'd2, 4'd3, 4'd6:        t = TONE_G4;
            4'd4, 4'd5:              t = TONE_A4;
            4'd7, 4'd8:              t = TONE_F4;
            4'd9, 4'd10:             t = TONE_E4;
            4'd11, 4'd12:            t = TONE_D4;
            default:                 t = '0;
        endcase
        return t;
    endfunction

    function automatic logic note_is_long(input logic [POS_W-1:0] idx);
        return (idx == 4'd6) || (idx == 4'd13);
    endfunction

    function automatic logic note_is_real(input logic [POS_W-1:0] idx);
        return idx < 4'd14;
    endfunction

endpackage

`default_nettype wire

@@ src/bms_if.sv @@
// Valid/ready channel interfaces for the button input and the result output.
// Depends on bms_pkg for field widths and the mode type.
`timescale 1ns / 1ps
`default_nettype none

interface bms_in_if;
    logic valid;
    logic ready;
    logic button;

    modport source (output valid, output button, input ready);
    modport sink   (input valid, input button, output ready);
endinterface

interface bms_out_if
    import bms_pkg::*;
;
    logic              valid;
    logic              ready;
    mode_t             mode;
    logic              sounding;
    logic [TONE_W-1:0] tone_period;
    logic [POS_W-1:0]  note_index;

    modport source (output valid, output mode, output sounding, output tone_period,
                    output note_index, input ready);
    modport sink   (input valid, input mode, input sounding, input tone_period,
                    input note_index, output ready);
endinterface

`default_nettype wire

@@ src/bms_cfg_regs.sv @@
// Configuration register file: note durations and gap length.
// Depends on bms_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module bms_cfg_regs
    import bms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output bms_cfg_t                  cfg
);

    bms_cfg_t cfg_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks <= SHORT_RST;
            cfg_reg.long_ticks  <= LONG_RST;
            cfg_reg.gap_ticks   <= GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT: cfg_reg.short_ticks <= cfg_data;
                REG_LONG:  cfg_reg.long_ticks  <= cfg_data;
                REG_GAP:   cfg_reg.gap_ticks   <= cfg_data[GAP_W-1:0];
                default:   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/bms_step.sv @@
// One tick of the melody sequencer: next mode, counters and result item.
// Depends on bms_pkg for types and song tables.
`timescale 1ns / 1ps
`default_nettype none

module bms_step
    import bms_pkg::*;
#(
    parameter int SONG_LENGTH = SONG_LENGTH_DEF
)
(
    input  wire bms_state_t cur,
    input  wire bms_cfg_t   cfg,
    input  wire logic       button,
    output bms_state_t      nxt,
    output bms_result_t     res
);

    localparam logic [POS_W:0] SongLen = (POS_W + 1)'(SONG_LENGTH);

    mode_t             mode_next;
    logic              in_song;
    logic [NOTE_W-1:0] dur;
    logic              snd;
    logic [TONE_W-1:0] period;

    assign in_song = {1'b0, cur.pos} < SongLen;

    // Mode transition
    always_comb
    begin
        case (cur.mode)
            MODE_OFF:      mode_next = button ? MODE_ARMED : MODE_OFF;
            MODE_ARMED:    mode_next = button ? MODE_ARMED : MODE_PLAYING;
            MODE_PLAYING:  mode_next = in_song ? MODE_PLAYING
                                     : (button ? MODE_FINISHED : MODE_OFF);
            MODE_FINISHED: mode_next = button ? MODE_FINISHED : MODE_OFF;
            default:       mode_next = MODE_OFF;
        endcase
    end

    // Duration of the current note
    always_comb
    begin
        if (!note_is_real(cur.pos))
            dur = '0;
        else if (note_is_long(cur.pos))
            dur = cfg.long_ticks;
        else
            dur = cfg.short_ticks;
    end

    // Sound, then gap, then advance to the next note; clear position and timers when the mode goes off
    always_comb
    begin
        nxt      = cur;
        nxt.mode = mode_next;
        snd      = 1'b0;
        period   = '0;
        if (mode_next == MODE_OFF)
        begin
            nxt.pos        = '0;
            nxt.note_timer = '0;
            nxt.gap_timer  = '0;
        end
        else if (mode_next == MODE_PLAYING && in_song)
        begin
            if (cur.note_timer < dur)
            begin
                snd            = 1'b1;
                period         = note_tone(cur.pos);
                nxt.note_timer = cur.note_timer + 1'b1;
            end
            else if (cur.gap_timer < cfg.gap_ticks)
            begin
                nxt.gap_timer = cur.gap_timer + 1'b1;
            end
            else
            begin
                nxt.note_timer = '0;
                nxt.gap_timer  = '0;
                nxt.pos        = cur.pos + 1'b1;
            end
        end
    end

    assign res.mode        = nxt.mode;
    assign res.sounding    = snd;
    assign res.tone_period = period;
    assign res.note_index  = nxt.pos;

endmodule

`default_nettype wire

@@ src/button_melody_sequencer.sv @@
// Top level of the button melody sequencer: input register, step logic,
// result register. Depends on bms_pkg, bms_if, bms_cfg_regs and bms_step.
//
// Usage: send one item per millisecond tick on in_ch carrying the button
// level. Each item yields exactly one result item on out_ch with the mode,
// the sounding flag, the tone compare value and the note index after the tick.
// Hold the button to arm, release to play the fourteen-note song; holding it
// through the end of the song parks the block in the finished mode.
// Path: an item accepted on in_ch passes the input register, then the result
// register, from which it is offered on out_ch. Throughput: one item per
// cycle while out_ch.ready stays high, set by the combinational state update
// between the two registers.
// Configuration: write short_note_ticks (0), long_note_ticks (1) and
// gap_ticks (2) through cfg_we/cfg_index/cfg_data while no item is in flight.
// Reset: registers return to 500, 1000 and 10 ticks; the mode returns to init
// and the counters to zero; both pipeline registers are emptied.
// Stall: while out_ch.ready is low the result is held and one more item is
// taken into the input register; in_ch.ready then drops until the stall ends.
`timescale 1ns / 1ps
`default_nettype none

module button_melody_sequencer
    import bms_pkg::*;
#(
    parameter int SONG_LENGTH = SONG_LENGTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    bms_in_if.sink                    in_ch,
    bms_out_if.source                 out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    bms_cfg_t    cfg;
    bms_state_t  state_reg;
    bms_state_t  state_next;
    bms_result_t res_next;
    bms_result_t res_reg;
    logic        in_valid_reg;
    logic        button_reg;
    logic        out_valid_reg;
    logic        advance;

    bms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bms_step #(
        .SONG_LENGTH (SONG_LENGTH)
    ) u_step (
        .cur    (state_reg),
        .cfg    (cfg),
        .button (button_reg),
        .nxt    (state_next),
        .res    (res_next)
    );

    // Move the held item on when the result register is free or being taken
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            button_reg <= in_ch.button;
        end
    end

    // Sequencer state: update once per item that advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_INIT;
            state_reg.pos        <= '0;
            state_reg.note_timer <= '0;
            state_reg.gap_timer  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.mode        = res_reg.mode;
    assign out_ch.sounding    = res_reg.sounding;
    assign out_ch.tone_period = res_reg.tone_period;
    assign out_ch.note_index  = res_reg.note_index;

endmodule

`default_nettype wire
